// File: design/fixed_partition_allocator_assert.svh
// Assertion macros used by the allocation engine (fpa_back) of the fixed partition allocator.
`ifndef FIXED_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPA_ASSERT(lbl, prop, msg)
`define FPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/fpa_pkg.sv
// Shared types, codes and defaults of the fixed partition allocator.
package fpa_pkg;

  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam int AMOUNT_W   = 16;
  localparam int SLOT_W     = 4;
  localparam int POLICY_W   = 2;
  localparam int COUNT_W    = 5;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  localparam logic REG_FIT_POLICY      = 1'b0;
  localparam logic REG_PARTITION_COUNT = 1'b1;

  typedef struct packed {
    logic [POLICY_W-1:0] policy;
    logic [COUNT_W-1:0]  count;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_WRITE
  } back_state_t;

endpackage

// File: design/fpa_ram.sv
// Generic single write port RAM with one registered read port.
module fpa_ram
  #(parameter int WIDTH = 16,
    parameter int DEPTH = 16)
  (input  logic                                         clk,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/fpa_front.sv
// Input stage: takes items, masks the amount and checks the load slot.
module fpa_front
  import fpa_pkg::*;
  #(parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = SIZE_BITS_DEF)
  (input  logic                        clk,
   input  logic                        rst,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        command,
   input  logic [SLOT_W-1:0]           partition_slot,
   input  logic [AMOUNT_W-1:0]         amount,
   input  logic                        final_request,
   output logic                        push_valid,
   input  logic                        push_ready,
   output logic [SIZE_BITS+SLOT_W+2:0] push_data);

  localparam int ENTRY_W = SIZE_BITS + SLOT_W + 3;

  logic               held;
  logic [ENTRY_W-1:0] entry;
  logic               slot_ok;

  assign slot_ok    = 32'(partition_slot) < NUM_PARTITIONS;
  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_data  = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      entry <= {command, slot_ok, partition_slot, SIZE_BITS'(amount), final_request};
    end
  end

endmodule

// File: design/fpa_queue.sv
// Short FIFO between the input stage and the allocation engine.
module fpa_queue
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 2)
  (input  logic             clk,
   input  logic             rst,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = 32'(fill) < DEPTH;
  assign pop_valid  = fill != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: design/fpa_back.sv
// Allocation engine: applies loads, scans the size table for requests and
// writes back the reduced size.
`include "fixed_partition_allocator_assert.svh"
module fpa_back
  import fpa_pkg::*;
  #(parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = SIZE_BITS_DEF)
  (input  logic                        clk,
   input  logic                        rst,
   input  cfg_t                        cfg,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  logic [SIZE_BITS+SLOT_W+2:0] pop_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic                        granted,
   output logic [SLOT_W-1:0]           chosen_partition,
   output logic [AMOUNT_W-1:0]         size_before,
   output logic                        batch_done);

  localparam int ENTRY_W = SIZE_BITS + SLOT_W + 3;
  localparam int IDX_W   = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CNT_W   = $clog2(NUM_PARTITIONS + 1);

  back_state_t state, state_next;

  // Fields of the item at the head of the queue.
  logic                 e_req;
  logic                 e_slot_ok;
  logic [SLOT_W-1:0]    e_slot;
  logic [SIZE_BITS-1:0] e_amt;
  logic                 e_last;

  logic [CNT_W-1:0]     limit_now;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     issue_cnt;
  logic [SIZE_BITS-1:0] req_amt;
  logic                 req_last;

  logic                 rd_pending;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_vld;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] pick_val;
  logic [NUM_PARTITIONS-1:0] ent_valid;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic                 start_req;
  logic                 out_load;

  logic [SIZE_BITS-1:0] cur_val;
  logic                 fits;
  logic                 take;

  assign e_last    = pop_data[0];
  assign e_amt     = pop_data[SIZE_BITS:1];
  assign e_slot    = pop_data[SIZE_BITS+SLOT_W:SIZE_BITS+1];
  assign e_slot_ok = pop_data[SIZE_BITS+SLOT_W+1];
  assign e_req     = pop_data[ENTRY_W-1] == CMD_REQUEST;

  assign limit_now = (32'(cfg.count) > NUM_PARTITIONS) ? CNT_W'(NUM_PARTITIONS)
                                                       : CNT_W'(cfg.count);

  // Entries never loaded since reset read as zero.
  assign cur_val = rd_vld ? ram_rdata : '0;
  assign fits    = cur_val >= req_amt;
  assign take    = fits && (!found ||
                            (cfg.policy == POLICY_BEST  && cur_val < pick_val) ||
                            (cfg.policy == POLICY_WORST && cur_val > pick_val));

  fpa_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_PARTITIONS)) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (pop_valid && e_req) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (issue_cnt == limit && !rd_pending) begin
          state_next = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    start_req = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      BK_IDLE: begin
        pop_ready = 1'b1;
        start_req = pop_valid && e_req;
        if (pop_valid && !e_req && e_slot_ok) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(e_slot);
          ram_wdata = e_amt;
        end
      end
      BK_SCAN: begin
        if (issue_cnt < limit) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(issue_cnt);
        end
      end
      BK_WRITE: begin
        out_load  = !out_valid || out_ready;
        ram_we    = out_load && found;
        ram_waddr = pick;
        ram_wdata = pick_val - req_amt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
      ent_valid  <= '0;
    end else begin
      state      <= state_next;
      rd_pending <= ram_re;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ram_raddr;
    rd_vld <= ent_valid[ram_raddr];
    if (start_req) begin
      issue_cnt <= '0;
      limit     <= limit_now;
      req_amt   <= e_amt;
      req_last  <= e_last;
      found     <= 1'b0;
    end else begin
      if (ram_re) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (rd_pending && take) begin
        found    <= 1'b1;
        pick     <= rd_idx;
        pick_val <= cur_val;
      end
    end
    if (out_load) begin
      granted          <= found;
      chosen_partition <= found ? SLOT_W'(pick) : '0;
      size_before      <= found ? AMOUNT_W'(pick_val) : '0;
      batch_done       <= req_last;
    end
  end

  `FPA_ASSERT(a_no_grant_zero, out_valid && !granted |-> chosen_partition == '0 && size_before == '0, "ungranted result carries nonzero fields")
  `FPA_ASSERT(a_write_state, ram_we |-> state == BK_IDLE || state == BK_WRITE, "table written during scan")
  `FPA_ASSERT(a_grant_fits, state == BK_WRITE && found |-> pick_val >= req_amt, "chosen partition too small")
  `FPA_ASSERT(a_issue_bound, state == BK_SCAN |-> issue_cnt <= limit, "scan ran past partition count")
  `FPA_ASSERT(a_result_after_write, $rose(out_valid) |-> $past(state) == BK_WRITE, "result without write-back")

endmodule

// File: design/fixed_partition_allocator.sv
// Top level of the fixed partition allocator: configuration registers and the
// front, queue and engine instances.
//
// The block keeps one free size per partition. A load item sets a partition's
// size and gives no result; a request item scans partitions 0 to
// partition_count-1 (saturated to NUM_PARTITIONS) under first, best or worst
// fit, reduces the chosen size and returns one result. Items pass an input
// register and a two-entry queue into the engine, so new items are taken
// while the engine works. The engine applies a load in the cycle it takes it.
// A request takes the item, issues one read per partition from the size RAM,
// waits for the last read to return, sees the read pipe empty and writes
// back. The write-back waits while the previous result has not been taken.
// The table reads as all zero after reset through per-entry valid flags, so
// there is no clearing pass. Unused policy code 3 behaves as first fit.
module fixed_partition_allocator
  import fpa_pkg::*;
  #(parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = SIZE_BITS_DEF)
  (input  logic                  clk,
   input  logic                  rst,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [APB_ADDR_W-1:0] paddr,
   input  logic [APB_DATA_W-1:0] pwdata,
   output logic [APB_DATA_W-1:0] prdata,
   output logic                  pready,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  command,
   input  logic [SLOT_W-1:0]     partition_slot,
   input  logic [AMOUNT_W-1:0]   amount,
   input  logic                  final_request,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  granted,
   output logic [SLOT_W-1:0]     chosen_partition,
   output logic [AMOUNT_W-1:0]   size_before,
   output logic                  batch_done);

  localparam int ENTRY_W = SIZE_BITS + SLOT_W + 3;

  cfg_t               cfg;
  logic               reg_sel;
  logic               f_valid;
  logic               f_ready;
  logic [ENTRY_W-1:0] f_data;
  logic               q_valid;
  logic               q_ready;
  logic [ENTRY_W-1:0] q_data;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy <= POLICY_FIRST;
      cfg.count  <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_FIT_POLICY:      cfg.policy <= pwdata[POLICY_W-1:0];
        REG_PARTITION_COUNT: cfg.count  <= pwdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIT_POLICY:      prdata = APB_DATA_W'(cfg.policy);
      REG_PARTITION_COUNT: prdata = APB_DATA_W'(cfg.count);
      default:             prdata = '0;
    endcase
  end

  fpa_front #(.NUM_PARTITIONS(NUM_PARTITIONS), .SIZE_BITS(SIZE_BITS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .partition_slot (partition_slot),
    .amount         (amount),
    .final_request  (final_request),
    .push_valid     (f_valid),
    .push_ready     (f_ready),
    .push_data      (f_data));

  fpa_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data));

  fpa_back #(.NUM_PARTITIONS(NUM_PARTITIONS), .SIZE_BITS(SIZE_BITS)) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .pop_valid        (q_valid),
    .pop_ready        (q_ready),
    .pop_data         (q_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .granted          (granted),
    .chosen_partition (chosen_partition),
    .size_before      (size_before),
    .batch_done       (batch_done));

endmodule
